/* rtl/ordered_list_insert_erase_store_macros.svh */
// Assertion macros shared by the list store RTL.
`ifndef ORDERED_LIST_INSERT_ERASE_STORE_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_STORE_MACROS_SVH

// same-cycle implication
`define OLIES_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLIES_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/olies_pkg.sv */
// Types and constants shared by the ordered list store modules.
`default_nettype none

package olies_pkg;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_INSERT   = 2'd1,
    OP_ERASE    = 2'd2,
    OP_RETRIEVE = 2'd3
  } op_e;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    op_e                operation;
    logic [5:0]         position;
    logic signed [31:0] element_value;
  } in_beat_t;

  typedef struct packed {
    logic               success;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic check;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_shift;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/olies_ctrl.sv */
// Controller state machine sequencing check, shift and finish steps.
`default_nettype none
`include "ordered_list_insert_erase_store_macros.svh"

module olies_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire olies_pkg::sts_t sts_i,
  output olies_pkg::cmd_t    cmd_o
);
  import olies_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.need_shift ? ST_SHIFT : ST_FINAL;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.last) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `OLIES_ASSERT_NEXT(a_accept_to_check, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == ST_CHECK, "accepted beat did not start check")
  `OLIES_ASSERT_NEXT(a_no_needless_shift, clk_i, rst_ni, state_q == ST_CHECK && !sts_i.need_shift, state_q == ST_FINAL, "shift entered without need")

endmodule

`default_nettype wire

/* rtl/olies_dp.sv */
// Datapath: entry memory, count, shift pointer, limit register and result register.
`default_nettype none
`include "ordered_list_insert_erase_store_macros.svh"

module olies_dp #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire olies_pkg::in_beat_t in_beat_i,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_wdata_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output olies_pkg::out_beat_t     out_beat_o,
  input  wire olies_pkg::cmd_t     cmd_i,
  output olies_pkg::sts_t          sts_o
);
  import olies_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

  in_beat_t                 item_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]            ptr_q, ptr_d;
  logic [ELEMENT_WIDTH-1:0] rdata_q;
  logic [6:0]               cap_q;
  out_beat_t                res_q, res_d;
  logic                     res_valid_q, res_valid_d;

  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;

  logic [CMP_W-1:0]         cnt_x, pos_x, cap_x, depth_x, ptr_x;
  logic [AW-1:0]            cnt_a, pos_a;
  logic                     room, in_range, ok, need_shift, last, out_free;
  logic                     is_insert;
  logic signed [63:0]       val64, rd64;
  logic signed [ELEMENT_WIDTH-1:0] rd_s;
  logic [ELEMENT_WIDTH-1:0] stored;

  assign cnt_x   = CMP_W'(cnt_q);
  assign pos_x   = CMP_W'(item_q.position);
  assign cap_x   = CMP_W'(cap_q);
  assign depth_x = CMP_W'(DEPTH);
  assign ptr_x   = CMP_W'(ptr_q);
  assign cnt_a   = cnt_x[AW-1:0];
  assign pos_a   = pos_x[AW-1:0];

  assign room      = (cnt_x < cap_x) && (cnt_x < depth_x);
  assign in_range  = pos_x < cnt_x;
  assign is_insert = (item_q.operation == OP_INSERT);

  always_comb begin
    ok         = 1'b0;
    need_shift = 1'b0;
    unique case (item_q.operation)
      OP_APPEND: ok = room;
      OP_INSERT: begin
        ok         = room && (pos_x <= cnt_x);
        need_shift = room && in_range;
      end
      OP_ERASE: begin
        ok         = in_range;
        need_shift = CMP_W'(pos_x + CMP_W'(1)) < cnt_x;
      end
      OP_RETRIEVE: ok = in_range;
    endcase
  end

  assign last = is_insert ? (ptr_x == CMP_W'(pos_x + CMP_W'(1)))
                          : (CMP_W'(ptr_x + CMP_W'(2)) == cnt_x);
  assign out_free = !res_valid_q || !out_stall_i;

  assign sts_o.need_shift = need_shift;
  assign sts_o.last       = last;
  assign sts_o.out_free   = out_free;

  assign val64  = 64'(item_q.element_value);
  assign stored = val64[ELEMENT_WIDTH-1:0];
  assign rd_s   = rdata_q;
  assign rd64   = 64'(rd_s);

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = pos_a;
    wr_en       = 1'b0;
    wr_addr     = pos_a;
    wr_data     = stored;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;

    if (res_valid_q && !out_stall_i) begin
      res_valid_d = 1'b0;
    end

    if (cmd_i.check) begin
      ptr_d = is_insert ? cnt_a : pos_a;
      rd_en = ok && ((item_q.operation == OP_RETRIEVE) || need_shift);
      unique case (item_q.operation)
        OP_INSERT: rd_addr = AW'(cnt_a - AW'(1));
        OP_ERASE:  rd_addr = AW'(pos_a + AW'(1));
        default:   rd_addr = pos_a;
      endcase
    end

    if (cmd_i.shift) begin
      wr_en   = 1'b1;
      wr_addr = ptr_q;
      wr_data = rdata_q;
      if (!last) begin
        rd_en   = 1'b1;
        rd_addr = is_insert ? AW'(ptr_q - AW'(2)) : AW'(ptr_q + AW'(2));
        ptr_d   = is_insert ? AW'(ptr_q - AW'(1)) : AW'(ptr_q + AW'(1));
      end
    end

    if (cmd_i.finish && out_free) begin
      res_valid_d        = 1'b1;
      res_d.success      = ok;
      res_d.read_value   = '0;
      if (ok) begin
        unique case (item_q.operation)
          OP_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = cnt_a;
            cnt_d   = CNT_W'(cnt_q + CNT_W'(1));
          end
          OP_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = pos_a;
            cnt_d   = CNT_W'(cnt_q + CNT_W'(1));
          end
          OP_ERASE: cnt_d = CNT_W'(cnt_q - CNT_W'(1));
          OP_RETRIEVE: res_d.read_value = rd64[31:0];
        endcase
      end
      res_d.entry_count = 7'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_beat_i;
    end
    ptr_q <= ptr_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_beat_o  = res_q;

  `OLIES_ASSERT_NEXT(a_fail_keeps_count, clk_i, rst_ni, cmd_i.finish && out_free && !ok, cnt_q == $past(cnt_q), "failed operation changed count")
  `OLIES_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, cnt_x <= depth_x, "count above depth")

endmodule

`default_nettype wire

/* rtl/ordered_list_insert_erase_store.sv */
// Ordered list store with shift insert and erase: top level.
// Input channel: in_valid_i / in_stall_o with in_beat_i (operation, position,
// element_value). Output channel: out_valid_o / out_stall_i with out_beat_o
// (success, read_value, entry_count). A beat moves when valid is high and
// stall is low. cfg_we_i writes cfg_wdata_i into the capacity limit.
// Each input beat gives exactly one output beat, in order.
// Entries live in a single-port-write, registered-read memory; insert and
// erase move one entry per cycle through it.
// An accepted beat passes through a check step, then one shift step per entry
// moved (count - position for insert, count - 1 - position for erase, none
// otherwise or on failure), then a final step that registers the result. A new
// beat is taken only in the idle state after the previous result is registered.
// The result register lets the next input beat be accepted while a result
// waits; if the receiver stalls, the following item holds in its last step
// until the register frees.
// Reset clears the count and the output valid and sets the limit to 64;
// memory contents are not cleared.
`default_nettype none

module ordered_list_insert_erase_store #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire olies_pkg::in_beat_t in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output olies_pkg::out_beat_t     out_beat_o,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_wdata_i
);
  import olies_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olies_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olies_dp #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

/* test/ordered_list_checker.sv */
// Checker for the ordered list store: watches the channels, predicts each result and compares.
`timescale 1ns / 100ps

module ordered_list_checker
  import olies_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_beat_t   in_beat_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_beat_t  out_beat_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int LIST_DEPTH = 64;

  logic [31:0] list_store [LIST_DEPTH];
  logic [6:0]  held;
  logic [6:0]  cap_limit;
  out_beat_t   expected_results [$];
  out_beat_t   want;
  int          fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic out_beat_t apply_list_op(input in_beat_t b);
    out_beat_t   r;
    int unsigned lim_eff;
    int unsigned pos;
    r       = '0;
    pos     = b.position;
    lim_eff = (cap_limit < LIST_DEPTH) ? cap_limit : LIST_DEPTH;
    case (b.operation)
      OP_APPEND: begin
        if (held < lim_eff) begin
          list_store[held] = b.element_value;
          held++;
          r.success = 1'b1;
        end
      end
      OP_INSERT: begin
        if (held < lim_eff && pos <= held) begin
          for (int unsigned k = held; k > pos; k--) list_store[k] = list_store[k-1];
          list_store[pos] = b.element_value;
          held++;
          r.success = 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos < held) begin
          for (int unsigned k = pos; k + 1 < held; k++) list_store[k] = list_store[k+1];
          held--;
          r.success = 1'b1;
        end
      end
      default: begin
        if (pos < held) begin
          r.read_value = list_store[pos];
          r.success    = 1'b1;
        end
      end
    endcase
    r.entry_count = held;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held      = '0;
      cap_limit = CAP_RESET;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat, expected none, got %p", $time, out_beat_i);
        end else begin
          want = expected_results.pop_front();
          if (out_beat_i.success !== want.success) begin
            fails++;
            $display("%0t: success mismatch, expected %0d, got %0d", $time,
                     want.success, out_beat_i.success);
          end
          if (out_beat_i.read_value !== want.read_value) begin
            fails++;
            $display("%0t: read_value mismatch, expected %0d, got %0d", $time,
                     want.read_value, out_beat_i.read_value);
          end
          if (out_beat_i.entry_count !== want.entry_count) begin
            fails++;
            $display("%0t: entry_count mismatch, expected %0d, got %0d", $time,
                     want.entry_count, out_beat_i.entry_count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(apply_list_op(in_beat_i));
      if (cfg_we_i) cap_limit = cfg_wdata_i;
      pending_o    <= expected_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the ordered list store: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import olies_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_beat = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_beat;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  int         fail_count;
  int         pending;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_armed = 1'b0;
  int unsigned approx_count = 0;
  int unsigned cap_setting = 64;

  always #5 clk = ~clk;

  ordered_list_insert_erase_store DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ordered_list_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, plus one long hold-off once armed
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        for (int unsigned c = 0; c < 300; c++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic in_beat_t op_beat(input op_e op, input logic [5:0] pos,
                                       input logic [31:0] val);
    in_beat_t b;
    b.operation     = op;
    b.position      = pos;
    b.element_value = val;
    return b;
  endfunction

  task automatic offer_op(input in_beat_t b);
    int unsigned lim_eff;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_beat  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    // rough fill level, only used to steer positions and the operation mix
    lim_eff = (cap_setting < 64) ? cap_setting : 64;
    case (b.operation)
      OP_APPEND: if (approx_count < lim_eff) approx_count++;
      OP_INSERT: if (approx_count < lim_eff && b.position <= approx_count) approx_count++;
      OP_ERASE:  if (b.position < approx_count) approx_count--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] v);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    cap_setting = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_ops(input int unsigned n_ops);
    in_beat_t    b;
    int unsigned r;
    int unsigned lim_eff;
    int unsigned top_pos;
    bit          draining;
    draining = 1'b0;
    for (int unsigned i = 0; i < n_ops; i++) begin
      lim_eff = (cap_setting < 64) ? cap_setting : 64;
      if (approx_count >= lim_eff) draining = 1'b1;
      else if (approx_count == 0) draining = 1'b0;
      else if ($urandom_range(99) < 2) draining = !draining;
      r = $urandom_range(99);
      if (r < (draining ? 10 : 30)) b.operation = OP_APPEND;
      else if (r < (draining ? 20 : 60)) b.operation = OP_INSERT;
      else if (r < (draining ? 65 : 75)) b.operation = OP_ERASE;
      else b.operation = OP_RETRIEVE;
      if (b.operation == OP_INSERT) top_pos = approx_count;
      else top_pos = (approx_count == 0) ? 0 : approx_count - 1;
      if (top_pos > 63) top_pos = 63;
      if ($urandom_range(99) < 85) b.position = 6'($urandom_range(top_pos, 0));
      else b.position = 6'($urandom_range(63, 0));
      case ($urandom_range(19))
        0:       b.element_value = 32'h8000_0000;
        1:       b.element_value = 32'h7FFF_FFFF;
        2:       b.element_value = 32'hFFFF_FFFF;
        3:       b.element_value = 32'h0000_0000;
        default: b.element_value = $urandom;
      endcase
      offer_op(b);
    end
  endtask

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small limit: empty list, fill to full, out of range, shifts
    write_capacity(7'd3);
    offer_op(op_beat(OP_RETRIEVE, 6'd0, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd0, 32'd0));
    offer_op(op_beat(OP_INSERT, 6'd1, 32'd5));
    offer_op(op_beat(OP_INSERT, 6'd0, 32'h8000_0000));
    offer_op(op_beat(OP_APPEND, 6'd63, 32'h7FFF_FFFF));
    offer_op(op_beat(OP_INSERT, 6'd2, 32'hFFFF_FFFF));
    offer_op(op_beat(OP_APPEND, 6'd0, 32'h1234_5678));
    offer_op(op_beat(OP_INSERT, 6'd0, 32'h1234_5678));
    offer_op(op_beat(OP_RETRIEVE, 6'd0, 32'hFFFF_FFFF));
    offer_op(op_beat(OP_RETRIEVE, 6'd1, 32'd0));
    offer_op(op_beat(OP_RETRIEVE, 6'd2, 32'd0));
    offer_op(op_beat(OP_RETRIEVE, 6'd3, 32'd0));
    offer_op(op_beat(OP_RETRIEVE, 6'd63, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd63, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd0, 32'd0));
    offer_op(op_beat(OP_RETRIEVE, 6'd0, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd1, 32'd0));
    offer_op(op_beat(OP_INSERT, 6'd0, 32'd0));
    wait_drained();

    // limit below the current count
    write_capacity(7'd1);
    offer_op(op_beat(OP_APPEND, 6'd0, 32'd7));
    offer_op(op_beat(OP_INSERT, 6'd0, 32'd7));
    offer_op(op_beat(OP_RETRIEVE, 6'd1, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd0, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd0, 32'd0));
    offer_op(op_beat(OP_APPEND, 6'd0, 32'hDEAD_BEEF));
    offer_op(op_beat(OP_APPEND, 6'd0, 32'd1));
    wait_drained();

    write_capacity(7'd0);
    offer_op(op_beat(OP_APPEND, 6'd0, 32'd3));
    offer_op(op_beat(OP_RETRIEVE, 6'd0, 32'd0));
    offer_op(op_beat(OP_ERASE, 6'd0, 32'd0));
    wait_drained();

    write_capacity(7'd64);
    tx_idle_pct = 12;
    rx_idle_pct <= 83;
    run_random_ops(500);
    wait_drained();

    write_capacity(7'd5);
    tx_idle_pct = 83;
    rx_idle_pct <= 12;
    run_random_ops(500);
    wait_drained();

    write_capacity(7'd127);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_armed  <= 1'b1;
    run_random_ops(500);
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
